// File: rtl/fwefo_pkg.sv
// Shared types, constants and helper functions for the four-wheel encoder
// filter and odometry unit. No dependencies; every other file imports this package.
package fwefo_pkg;

  // Number of wheels, which is also the number of filter lanes.
  localparam int unsigned NumWheels = 4;

  // Widths of the count, speed and position fields.
  localparam int unsigned DataW = 16;
  localparam int unsigned WideW = DataW + 1;   // holds a negated -32768
  localparam int unsigned NumW  = 21;          // weighted sum, at most 10 * 32768
  localparam int unsigned MagW  = 19;          // magnitude of the weighted sum
  localparam int unsigned ProdW = 2 * MagW;

  // Division by ten: n / 10 == (n * RecipTen) >> RecipShift for every n below 2^19.
  localparam logic [MagW-1:0] RecipTen   = 19'd419431;
  localparam int unsigned     RecipShift = 22;

  // The filter weights are given in tenths.
  localparam logic [3:0] WeightFull = 4'd10;

  // Register map, indexed by word address.
  typedef enum logic {
    REG_WEIGHT = 1'b0,
    REG_INVERT = 1'b1
  } reg_idx_e;

  // Register values as the lanes see them.
  typedef struct packed {
    logic [3:0] new_w;    // weight of the new count, clamped to ten
    logic [3:0] old_w;    // weight of the previous speed, ten minus new_w
    logic [3:0] invert;   // one bit per wheel, negates the count
  } cfg_t;

  typedef logic signed [DataW-1:0] speed_t;

  // Multiply a value by a weight from zero to ten with shifts and adds.
  function automatic logic signed [NumW-1:0] fwefo_scale(input logic signed [WideW-1:0] v,
                                                         input logic [3:0] k);
    logic signed [NumW-1:0] x;
    logic signed [NumW-1:0] r;
    x = NumW'(v);
    case (k)
      4'd0:    r = '0;
      4'd1:    r = x;
      4'd2:    r = x <<< 1;
      4'd3:    r = (x <<< 1) + x;
      4'd4:    r = x <<< 2;
      4'd5:    r = (x <<< 2) + x;
      4'd6:    r = (x <<< 2) + (x <<< 1);
      4'd7:    r = (x <<< 3) - x;
      4'd8:    r = x <<< 3;
      4'd9:    r = (x <<< 3) + x;
      default: r = (x <<< 3) + (x <<< 1);
    endcase
    return r;
  endfunction

endpackage

// File: rtl/fwefo_if.sv
// Valid/ready channel interfaces for the encoder counts and the odometry results.
// Depends on fwefo_pkg for the field widths.
interface fwefo_in_if
  import fwefo_pkg::*;
  ();
  logic                    valid;
  logic                    ready;
  logic signed [DataW-1:0] count_1;
  logic signed [DataW-1:0] count_2;
  logic signed [DataW-1:0] count_3;
  logic signed [DataW-1:0] count_4;

  modport source (output valid, count_1, count_2, count_3, count_4, input ready);
  modport sink   (input valid, count_1, count_2, count_3, count_4, output ready);
endinterface

interface fwefo_out_if
  import fwefo_pkg::*;
  ();
  logic                    valid;
  logic                    ready;
  logic signed [DataW-1:0] speed_1;
  logic signed [DataW-1:0] speed_2;
  logic signed [DataW-1:0] speed_3;
  logic signed [DataW-1:0] speed_4;
  logic signed [DataW-1:0] pos_x;
  logic signed [DataW-1:0] pos_y;

  modport source (output valid, speed_1, speed_2, speed_3, speed_4, pos_x, pos_y,
                  input ready);
  modport sink   (input valid, speed_1, speed_2, speed_3, speed_4, pos_x, pos_y,
                  output ready);
endinterface

// File: rtl/fwefo_regs.sv
// APB-style configuration registers: filter weight and per-wheel invert mask.
// Depends on fwefo_pkg for the register map and the cfg_t struct.
module fwefo_regs
  import fwefo_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output cfg_t        cfg_o
);

  logic [3:0] weight_q, weight_d;
  logic [3:0] invert_q, invert_d;
  logic       wr_en;
  reg_idx_e   idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = reg_idx_e'(paddr[2]);

  // Write decode.
  always_comb begin
    weight_d = weight_q;
    invert_d = invert_q;
    if (wr_en) begin
      unique case (idx)
        REG_WEIGHT: weight_d = pwdata[3:0];
        REG_INVERT: invert_d = pwdata[3:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      weight_q <= 4'd3;
      invert_q <= 4'd10;
    end else begin
      weight_q <= weight_d;
      invert_q <= invert_d;
    end
  end

  // Read decode.
  always_comb begin
    unique case (idx)
      REG_WEIGHT: prdata = {28'd0, weight_q};
      REG_INVERT: prdata = {28'd0, invert_q};
      default:    prdata = '0;
    endcase
  end

  // Weights above ten act as ten.
  always_comb begin
    cfg_o.new_w  = (weight_q > WeightFull) ? WeightFull : weight_q;
    cfg_o.old_w  = WeightFull - cfg_o.new_w;
    cfg_o.invert = invert_q;
  end

endmodule

// File: rtl/fwefo_lane.sv
// One wheel lane: optional negation, first-order low-pass filter in tenths,
// truncating division by ten and saturation. Depends on fwefo_pkg.
module fwefo_lane
  import fwefo_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        accept_i,
  input  speed_t      count_i,
  input  logic        invert_i,
  input  logic [3:0]  new_w_i,
  input  logic [3:0]  old_w_i,
  output speed_t      speed_o
);

  speed_t                   speed_q, speed_d;
  logic signed [WideW-1:0]  cnt_ext;
  logic signed [WideW-1:0]  cnt;
  logic signed [WideW-1:0]  prev;
  logic signed [NumW-1:0]   num;
  logic                     num_neg;
  logic        [NumW-1:0]   num_abs;
  logic        [ProdW-1:0]  prod;
  logic        [DataW-1:0]  q_mag;
  logic signed [WideW-1:0]  q_signed;

  // Negate the count if the mask asks for it; 17 bits keep +32768.
  assign cnt_ext = WideW'(count_i);
  assign cnt     = invert_i ? -cnt_ext : cnt_ext;
  assign prev    = WideW'(speed_q);

  // Weighted sum of the new count and the previous speed.
  assign num     = fwefo_scale(cnt, new_w_i) + fwefo_scale(prev, old_w_i);
  assign num_neg = num[NumW-1];
  assign num_abs = num_neg ? NumW'(-num) : NumW'(num);

  // Divide the magnitude by ten through the reciprocal, then restore the sign.
  assign prod     = ProdW'(num_abs[MagW-1:0]) * ProdW'(RecipTen);
  assign q_mag    = prod[RecipShift +: DataW];
  assign q_signed = num_neg ? -$signed({1'b0, q_mag}) : $signed({1'b0, q_mag});

  // Only +32768 can leave the 16-bit range; it saturates.
  always_comb begin
    if (!num_neg && q_mag[DataW-1]) begin
      speed_d = speed_t'({1'b0, {(DataW-1){1'b1}}});
    end else begin
      speed_d = q_signed[DataW-1:0];
    end
  end

  // The speed register is also the filter state for the next transfer.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      speed_q <= '0;
    end else if (accept_i) begin
      speed_q <= speed_d;
    end
  end

  assign speed_o = speed_q;

endmodule

// File: rtl/fwefo_merge.sv
// Merge stage: combines the four lane speeds into mecanum x/y increments,
// keeps the wrapping position accumulators and the output register. Depends on fwefo_pkg.
module fwefo_merge
  import fwefo_pkg::*;
(
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   load_i,
  input  speed_t speed_i [NumWheels],
  output speed_t speed_o [NumWheels],
  output speed_t pos_x_o,
  output speed_t pos_y_o
);

  logic signed [DataW+1:0] sum_x;
  logic signed [DataW+1:0] sum_y;
  logic signed [DataW+1:0] adj_x;
  logic signed [DataW+1:0] adj_y;
  speed_t                  dx, dy;
  speed_t                  acc_x_q, acc_x_d;
  speed_t                  acc_y_q, acc_y_d;
  speed_t                  speed_q [NumWheels];

  // Mecanum sums over the four wheels.
  assign sum_x = (DataW+2)'(speed_i[0]) + (DataW+2)'(speed_i[1])
               + (DataW+2)'(speed_i[2]) + (DataW+2)'(speed_i[3]);
  assign sum_y = (DataW+2)'(speed_i[1]) + (DataW+2)'(speed_i[2])
               - (DataW+2)'(speed_i[0]) - (DataW+2)'(speed_i[3]);

  // Quarter, truncated toward zero: bias negative sums by three before the shift.
  assign adj_x = sum_x + (sum_x[DataW+1] ? (DataW+2)'(3) : (DataW+2)'(0));
  assign adj_y = sum_y + (sum_y[DataW+1] ? (DataW+2)'(3) : (DataW+2)'(0));
  assign dx    = adj_x[DataW+1:2];
  assign dy    = adj_y[DataW+1:2];

  // Positions wrap at 16 bits.
  assign acc_x_d = acc_x_q + dx;
  assign acc_y_d = acc_y_q + dy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_x_q <= '0;
      acc_y_q <= '0;
    end else if (load_i) begin
      acc_x_q <= acc_x_d;
      acc_y_q <= acc_y_d;
    end
  end

  // Output copy of the speeds, held while the receiver stalls.
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      speed_q <= speed_i;
    end
  end

  assign speed_o = speed_q;
  assign pos_x_o = acc_x_q;
  assign pos_y_o = acc_y_q;

endmodule

// File: rtl/four_wheel_encoder_filter_odometry_unit.sv
// Top level of the four-wheel encoder filter and odometry unit.
// Depends on fwefo_pkg, fwefo_if, fwefo_regs, fwefo_lane and fwefo_merge.
//
// Usage:
//   in_i carries the four signed encoder counts of one sample period; out_o
//   returns the four filtered wheel speeds and the accumulated x/y position.
//   Every input transfer produces exactly one output transfer, in order.
//   The APB-style port holds the filter weight (address 0) and the invert
//   mask (address 4); write them only while no transfer is in flight.
// Pipeline and throughput:
//   The result of an input transfer is registered first in the four filter
//   lanes and then in the merge stage. The filter recurrence closes within
//   the lane stage, so a new item is taken every cycle unless a stall on
//   out_o holds the pipeline.
// Reset:
//   rst_ni clears the filter state, the positions and both valid flags, and
//   loads the weight with three and the invert mask with ten.
// Stall:
//   While out_o.ready is low, the output register holds its result; the lane
//   stage can still take one more item, after which in_i.ready drops.
module four_wheel_encoder_filter_odometry_unit
  import fwefo_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  fwefo_in_if.sink        in_i,
  fwefo_out_if.source     out_o,
  input  logic            psel,
  input  logic            penable,
  input  logic            pwrite,
  input  logic [2:0]      paddr,
  input  logic [31:0]     pwdata,
  output logic [31:0]     prdata,
  output logic            pready
);

  cfg_t   cfg;
  speed_t count   [NumWheels];
  speed_t lane_sp [NumWheels];
  speed_t out_sp  [NumWheels];
  speed_t pos_x, pos_y;
  logic   lane_vld_q, lane_vld_d;
  logic   out_vld_q, out_vld_d;
  logic   out_free;
  logic   lane_move;
  logic   in_take;

  fwefo_regs u_regs (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready),
    .cfg_o  (cfg)
  );

  // Pipeline control: the output register frees when empty or taken.
  assign out_free  = !out_vld_q || out_o.ready;
  assign lane_move = lane_vld_q && out_free;
  assign in_i.ready = !lane_vld_q || out_free;
  assign in_take   = in_i.valid && in_i.ready;

  always_comb begin
    lane_vld_d = in_take ? 1'b1 : (lane_move ? 1'b0 : lane_vld_q);
    out_vld_d  = lane_move ? 1'b1 : (out_o.ready ? 1'b0 : out_vld_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lane_vld_q <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      lane_vld_q <= lane_vld_d;
      out_vld_q  <= out_vld_d;
    end
  end

  assign count[0] = in_i.count_1;
  assign count[1] = in_i.count_2;
  assign count[2] = in_i.count_3;
  assign count[3] = in_i.count_4;

  // One filter lane per wheel.
  for (genvar g = 0; g < NumWheels; g++) begin : g_lane
    fwefo_lane u_lane (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .accept_i(in_take),
      .count_i (count[g]),
      .invert_i(cfg.invert[g]),
      .new_w_i (cfg.new_w),
      .old_w_i (cfg.old_w),
      .speed_o (lane_sp[g])
    );
  end

  fwefo_merge u_merge (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .load_i (lane_move),
    .speed_i(lane_sp),
    .speed_o(out_sp),
    .pos_x_o(pos_x),
    .pos_y_o(pos_y)
  );

  assign out_o.valid   = out_vld_q;
  assign out_o.speed_1 = out_sp[0];
  assign out_o.speed_2 = out_sp[1];
  assign out_o.speed_3 = out_sp[2];
  assign out_o.speed_4 = out_sp[3];
  assign out_o.pos_x   = pos_x;
  assign out_o.pos_y   = pos_y;

endmodule

// File: tb/four_wheel_encoder_filter_odometry_unit_tb.sv
`timescale 1ns / 1ps
// Testbench for the four-wheel encoder filter and odometry unit: directed and random
// encoder counts, each result checked field by field against a behavioral filter model.
// Depends on fwefo_pkg, the fwefo_if channel interfaces and the unit's RTL.
module four_wheel_encoder_filter_odometry_unit_tb
  import fwefo_pkg::*;
();

  localparam int unsigned ClkHalf       = 5;
  localparam int unsigned ResetCycles   = 8;
  localparam int unsigned IdleLimit     = 2000;
  localparam int unsigned HoldOffCycles = 300;
  localparam int unsigned SettleCycles  = 4;
  localparam int unsigned DrainCycles   = 8;
  localparam int unsigned RandomPhases  = 8;
  localparam int unsigned ItemsPerPhase = 250;
  localparam logic [3:0]  ResetWeight   = 4'd3;
  localparam logic [3:0]  ResetInvert   = 4'd10;
  localparam speed_t      CountMax      = 16'sh7fff;
  localparam speed_t      CountMin      = 16'sh8000;

  typedef speed_t [NumWheels-1:0] counts_t;

  typedef struct packed {
    counts_t speed;
    speed_t  pos_x;
    speed_t  pos_y;
  } odo_result_t;

  logic        clk_i;
  logic        rst_ni;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  fwefo_in_if  in_bus ();
  fwefo_out_if out_bus ();

  four_wheel_encoder_filter_odometry_unit i_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_bus),
    .out_o   (out_bus),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Model state: register copies, filter memory and the two position accumulators.
  logic [3:0]  cfg_weight;
  logic [3:0]  cfg_invert;
  speed_t      filt_prev [NumWheels];
  speed_t      pos_x_acc;
  speed_t      pos_y_acc;
  odo_result_t odo_expected [$];
  odo_result_t odo_want;

  int unsigned mismatches;
  int unsigned result_idx;
  bit          src_gaps_on;
  bit          stall_on;
  int unsigned hold_cycles;

  initial clk_i = 1'b0;
  always #(ClkHalf) clk_i = ~clk_i;

  // Filter and odometry update for one accepted set of counts.
  function automatic odo_result_t predict_odometry(input counts_t cnt);
    odo_result_t r;
    int          w;
    int          c;
    int          q;
    int          dx;
    int          dy;
    w = (cfg_weight > WeightFull) ? int'(WeightFull) : int'(cfg_weight);
    for (int i = 0; i < NumWheels; i++) begin
      c = int'(cnt[i]);
      if (cfg_invert[i]) c = -c;
      q = (w * c + (int'(WeightFull) - w) * int'(filt_prev[i])) / int'(WeightFull);
      // Only a negated most-negative count at full weight can exceed the range.
      if (q > 32767) q = 32767;
      if (q < -32768) q = -32768;
      filt_prev[i] = speed_t'(q);
      r.speed[i] = filt_prev[i];
    end
    dx = (int'(filt_prev[0]) + int'(filt_prev[1]) + int'(filt_prev[2])
          + int'(filt_prev[3])) / 4;
    dy = (int'(filt_prev[1]) + int'(filt_prev[2]) - int'(filt_prev[0])
          - int'(filt_prev[3])) / 4;
    pos_x_acc = pos_x_acc + speed_t'(dx);
    pos_y_acc = pos_y_acc + speed_t'(dy);
    r.pos_x = pos_x_acc;
    r.pos_y = pos_y_acc;
    return r;
  endfunction

  // Mostly short gaps, now and then a long one.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r < 6) return $urandom_range(1, 2);
    else if (r < 9) return $urandom_range(3, 6);
    return $urandom_range(15, 40);
  endfunction

  // Count values weighted toward the extremes and small speeds.
  function automatic speed_t rand_count();
    case ($urandom_range(0, 9))
      0:       return CountMin;
      1:       return CountMax;
      2, 3, 4: return speed_t'(int'($urandom_range(0, 400)) - 200);
      default: return speed_t'($urandom());
    endcase
  endfunction

  function automatic counts_t rand_counts();
    counts_t cnt;
    for (int i = 0; i < NumWheels; i++) cnt[i] = rand_count();
    return cnt;
  endfunction

  task automatic report(input string msg);
    $display("ERROR: %s", msg);
    mismatches++;
  endtask

  task automatic check_field(input string name, input speed_t got, input speed_t want);
    if (got !== want) begin
      report($sformatf("result %0d %s: got %0d, expected %0d", result_idx, name, got, want));
    end
  endtask

  // One register transfer: setup cycle, then access until pready.
  task automatic apb_access(input bit wr, input reg_idx_e idx, input logic [31:0] data,
                            output logic [31:0] rd);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    rd = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic check_register(input reg_idx_e idx, input logic [3:0] want);
    logic [31:0] rd;
    apb_access(1'b0, idx, '0, rd);
    if (rd[3:0] !== want) begin
      report($sformatf("register %s reads %0d, expected %0d", idx.name(), rd[3:0], want));
    end
  endtask

  // Upper data bits are random; only the low four bits are kept.
  task automatic write_register(input reg_idx_e idx, input logic [3:0] value);
    logic [31:0] data;
    logic [31:0] rd;
    data      = $urandom();
    data[3:0] = value;
    apb_access(1'b1, idx, data, rd);
    case (idx)
      REG_WEIGHT: cfg_weight = value;
      REG_INVERT: cfg_invert = value;
      default: ;
    endcase
    check_register(idx, value);
  endtask

  // Offers one set of counts and returns at the edge where it is transferred.
  task automatic send_counts(input counts_t cnt);
    int unsigned gap;
    gap = (src_gaps_on && $urandom_range(0, 2) == 0) ? pick_gap() : 0;
    if (gap != 0) begin
      in_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_bus.valid   <= 1'b1;
    in_bus.count_1 <= cnt[0];
    in_bus.count_2 <= cnt[1];
    in_bus.count_3 <= cnt[2];
    in_bus.count_4 <= cnt[3];
    do @(posedge clk_i); while (!in_bus.ready);
  endtask

  // Stops offering and lets every pending result drain out of the pipeline.
  // The first edge lets the transfer of the last item reach the queue.
  task automatic wait_idle();
    in_bus.valid <= 1'b0;
    @(posedge clk_i);
    while (odo_expected.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic test_reset_defaults();
    check_register(REG_WEIGHT, ResetWeight);
    check_register(REG_INVERT, ResetInvert);
    send_counts('0);
    send_counts({NumWheels{CountMax}});
    // Default mask negates the most negative count on wheels two and four.
    send_counts({NumWheels{CountMin}});
    send_counts({CountMin, 16'shffff, 16'sh0001, CountMax});
  endtask

  task automatic test_weight_extremes();
    // Zero weight: the filter holds its previous value.
    wait_idle();
    write_register(REG_WEIGHT, 4'd0);
    write_register(REG_INVERT, 4'h0);
    send_counts({16'sh1234, CountMin, CountMax, 16'sh0001});
    send_counts({CountMax, CountMax, CountMin, CountMin});
    // Full weight with all counts negated: the filter saturates at the top.
    wait_idle();
    write_register(REG_WEIGHT, WeightFull);
    write_register(REG_INVERT, 4'hf);
    send_counts({NumWheels{CountMin}});
    // Weights above ten act as ten.
    wait_idle();
    write_register(REG_WEIGHT, 4'hf);
    write_register(REG_INVERT, 4'h0);
    send_counts({16'sh0123, 16'shfedc, CountMax, CountMin});
    send_counts({16'sh7001, 16'sh8ffe, 16'sh0000, 16'sh5555});
  endtask

  task automatic test_position_wrap();
    wait_idle();
    write_register(REG_WEIGHT, WeightFull);
    write_register(REG_INVERT, 4'h0);
    // Large equal speeds push x past both ends of its range.
    repeat (6) send_counts({NumWheels{CountMax}});
    repeat (6) send_counts({NumWheels{CountMin}});
    // Opposing wheel pairs drive y as far as it goes.
    repeat (4) send_counts({CountMin, CountMax, CountMax, CountMin});
  endtask

  task automatic test_backpressure();
    wait_idle();
    src_gaps_on = 1'b0;
    stall_on    = 1'b0;
    hold_cycles = HoldOffCycles;
    repeat (40) send_counts(rand_counts());
  endtask

  task automatic test_random_configs();
    logic [3:0] w;
    logic [3:0] m;
    for (int p = 0; p < RandomPhases; p++) begin
      w = 4'($urandom_range(0, 15));
      m = 4'($urandom_range(0, 15));
      if (p == 0) begin
        w = 4'd0;
        m = 4'h0;
      end else if (p == 1) begin
        w = WeightFull;
        m = 4'hf;
      end else if (p == 2) begin
        w = 4'hf;
      end
      wait_idle();
      write_register(REG_WEIGHT, w);
      write_register(REG_INVERT, m);
      src_gaps_on = (p == 3) ? 1'b0 : (p == 4) ? 1'b1 : 1'($urandom_range(0, 1));
      stall_on    = (p == 3) ? 1'b0 : (p == 4) ? 1'b1 : 1'($urandom_range(0, 1));
      repeat (ItemsPerPhase) send_counts(rand_counts());
    end
  endtask

  // Main sequence.
  initial begin
    rst_ni         <= 1'b0;
    in_bus.valid   <= 1'b0;
    in_bus.count_1 <= '0;
    in_bus.count_2 <= '0;
    in_bus.count_3 <= '0;
    in_bus.count_4 <= '0;
    psel           <= 1'b0;
    penable        <= 1'b0;
    pwrite         <= 1'b0;
    paddr          <= '0;
    pwdata         <= '0;
    cfg_weight  = ResetWeight;
    cfg_invert  = ResetInvert;
    for (int i = 0; i < NumWheels; i++) filt_prev[i] = '0;
    pos_x_acc   = '0;
    pos_y_acc   = '0;
    mismatches  = 0;
    result_idx  = 0;
    hold_cycles = 0;
    src_gaps_on = 1'b1;
    stall_on    = 1'b1;
    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_defaults();
    test_weight_extremes();
    test_position_wrap();
    test_backpressure();
    test_random_configs();
    wait_idle();
    repeat (DrainCycles) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Result receiver: random stalls, plus one long hold-off on request.
  initial begin
    out_bus.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_cycles != 0) begin
        out_bus.ready <= 1'b0;
        repeat (hold_cycles) @(posedge clk_i);
        hold_cycles = 0;
      end else if (stall_on && $urandom_range(0, 3) == 0) begin
        out_bus.ready <= 1'b0;
        repeat (pick_gap()) @(posedge clk_i);
      end
      out_bus.ready <= 1'b1;
    end
  end

  // Every count transfer queues its expected result.
  always @(posedge clk_i) begin
    if (rst_ni && in_bus.valid && in_bus.ready) begin
      odo_expected.push_back(predict_odometry({in_bus.count_4, in_bus.count_3,
                                               in_bus.count_2, in_bus.count_1}));
    end
  end

  // Every result transfer is compared with the oldest expectation.
  always @(posedge clk_i) begin
    if (rst_ni && out_bus.valid && out_bus.ready) begin
      if (odo_expected.size() == 0) begin
        report($sformatf("result %0d arrived with none expected", result_idx));
      end else begin
        odo_want = odo_expected.pop_front();
        check_field("speed_1", out_bus.speed_1, odo_want.speed[0]);
        check_field("speed_2", out_bus.speed_2, odo_want.speed[1]);
        check_field("speed_3", out_bus.speed_3, odo_want.speed[2]);
        check_field("speed_4", out_bus.speed_4, odo_want.speed[3]);
        check_field("pos_x", out_bus.pos_x, odo_want.pos_x);
        check_field("pos_y", out_bus.pos_y, odo_want.pos_y);
      end
      result_idx++;
    end
  end

  // Watchdog: too long without any transfer on any port ends the run.
  initial begin
    int unsigned quiet;
    quiet = 0;
    while (quiet < IdleLimit) begin
      @(posedge clk_i);
      if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready)
          || (psel && penable && pready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("Mismatches found");
    $finish;
  end

endmodule
